### src/dpw_pkg.sv
package dpw_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FOCAL_X = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y = 3'd1;
  localparam logic [2:0] REG_CENTRE_X = 3'd2;
  localparam logic [2:0] REG_CENTRE_Y = 3'd3;
  localparam logic [2:0] REG_HORIZON = 3'd4;

  // Item kinds on the input channel.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_POSE = 1'b1;

  // Pose word layout.
  localparam int ROT_WORDS = 9;
  localparam int POSE_T_BASE = 9;
  localparam int POSE_B_BASE = 12;
  localparam int POSE_WORDS = 15;

  // Pipelined divider geometry.
  localparam int DIV_W = 36;
  localparam int DIVISOR_W = 18;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  // Item information that travels alongside the arithmetic.
  typedef struct packed {
    logic vld;
    logic is_pose;
    logic [3:0] pidx;
    logic signed [31:0] pval;
    logic [19:0] depth;
    logic sx;
    logic sy;
  } dpw_side_t;

endpackage

### src/dpw_div.sv
module dpw_div
  import dpw_pkg::*;
(
  input logic clk,
  input logic en,
  input logic [DIV_W-1:0] dividend,
  input logic [DIVISOR_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient
);

  // Each stage holds the partly shifted dividend with quotient bits shifted in
  // from the right; all but the last stage also hold the running remainder.
  logic [DIV_W-1:0] dq [DIV_STAGES];
  logic [DIVISOR_W-1:0] rem [DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_W-1:0] dq_in;
    logic [DIV_W-1:0] dq_next;
    logic [DIVISOR_W-1:0] rem_in;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W:0] trial;
    logic qbit;

    if (k == 0) begin : g_first
      assign dq_in = dividend;
      assign rem_in = '0;
    end else begin : g_rest
      assign dq_in = dq[k-1];
      assign rem_in = rem[k-1];
    end

    // Restoring division, a fixed number of quotient bits per stage.
    always_comb begin
      dq_next = dq_in;
      rem_next = rem_in;
      trial = '0;
      qbit = 1'b0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {rem_next, dq_next[DIV_W-1]};
        if (trial >= {1'b0, divisor}) begin
          rem_next = DIVISOR_W'(trial - {1'b0, divisor});
          qbit = 1'b1;
        end else begin
          rem_next = trial[DIVISOR_W-1:0];
          qbit = 1'b0;
        end
        dq_next = {dq_next[DIV_W-2:0], qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[k] <= dq_next;
      end
    end

    if (k < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rem_next;
        end
      end
    end
  end

  assign quotient = dq[DIV_STAGES-1];

endmodule

### src/depth_pixel_to_world_point.sv
// Depth pixel to world point back-projection.
// Items enter on the item channel (item_valid / item_stall). An item with
// op = pixel carries col, row and depth_mm; one with op = pose loads pose word
// pose_index with pose_value (rotation Q1.16, camera translation, body position).
// Kept points leave on the point channel (point_valid / point_stall) as
// world_x, world_y and world_z in millimetres. Pixels with no return, too far,
// outside the image or beyond the horizon produce no transfer at all.
// Focal lengths, principal point and horizon are set through the write port
// (cfg_write, cfg_index, cfg_data) while no item is in flight.
// One item transfers per clock while item_stall is low. A kept point passes
// through 3 input stages, 18 stages of the two-bit-per-stage divider that forms
// the camera x and y coordinates, 8 stages of rotation, translation and range
// test, and the output register.
// Pose loads travel through the same stages and take effect in order.
// Reset empties the pipeline, restores the identity rotation with zero
// translations and the default camera registers.
// While point_stall holds a point, the pipeline keeps moving until a kept point
// waits behind the output register; only then does item_stall rise.
module depth_pixel_to_world_point
  import dpw_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int DEPTH_LIMIT_MM = 500000
) (
  input logic clk,
  input logic rst,
  input logic item_valid,
  output logic item_stall,
  input logic op,
  input logic [10:0] col,
  input logic [10:0] row,
  input logic [19:0] depth_mm,
  input logic [3:0] pose_index,
  input logic signed [31:0] pose_value,
  output logic point_valid,
  input logic point_stall,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  input logic cfg_write,
  input logic [2:0] cfg_index,
  input logic [19:0] cfg_data
);

  localparam logic [13:0] WIDTH_LIM = 14'(MAX_WIDTH);
  localparam logic [13:0] HEIGHT_LIM = 14'(MAX_HEIGHT);
  localparam logic [19:0] DEPTH_LIM = 20'(DEPTH_LIMIT_MM);

  function automatic logic signed [17:0] clamp_rot(input logic signed [31:0] w);
    logic signed [17:0] r;
    if (w > 32'sd131071) begin
      r = 18'sh1ffff;
    end else if (w < -32'sd131072) begin
      r = 18'sh20000;
    end else begin
      r = w[17:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Camera registers.
  logic [17:0] focal_x;
  logic [17:0] focal_y;
  logic [14:0] centre_x;
  logic [14:0] centre_y;
  logic [19:0] horizon_mm;
  logic [39:0] horizon_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 18'd6400;
      focal_y <= 18'd6400;
      centre_x <= 15'd5120;
      centre_y <= 15'd3840;
      horizon_mm <= 20'd5000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOCAL_X: focal_x <= cfg_data[17:0];
        REG_FOCAL_Y: focal_y <= cfg_data[17:0];
        REG_CENTRE_X: centre_x <= cfg_data[14:0];
        REG_CENTRE_Y: centre_y <= cfg_data[14:0];
        REG_HORIZON: horizon_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // The squared horizon follows the register; it settles long before use.
  always_ff @(posedge clk) begin
    horizon_sq <= {20'd0, horizon_mm} * {20'd0, horizon_mm};
  end

  // A zero focal length acts as one.
  logic [17:0] fx_eff;
  logic [17:0] fy_eff;
  assign fx_eff = (focal_x == '0) ? 18'd1 : focal_x;
  assign fy_eff = (focal_y == '0) ? 18'd1 : focal_y;

  // The whole pipeline moves unless a kept point cannot enter the output register.
  logic adv;
  logic accept;
  logic e_vld;
  assign adv = !(e_vld && point_valid && point_stall);
  assign item_stall = !adv;
  assign accept = item_valid && adv;

  // Stage 0: filter the item and form the pixel offsets from the principal point.
  logic signed [16:0] off_x;
  logic signed [16:0] off_y;
  logic pix_ok;
  logic pose_ok;
  dpw_side_t s0_side_next;

  assign off_x = $signed({2'b00, col, 4'b0000}) - $signed({2'b00, centre_x});
  assign off_y = $signed({2'b00, row, 4'b0000}) - $signed({2'b00, centre_y});
  assign pix_ok = ({3'b000, col} < WIDTH_LIM) && ({3'b000, row} < HEIGHT_LIM) &&
                  (depth_mm != '0) && (depth_mm < DEPTH_LIM);
  assign pose_ok = pose_index < 4'(POSE_WORDS);

  always_comb begin
    s0_side_next.vld = accept && ((op == OP_POSE) ? pose_ok : pix_ok);
    s0_side_next.is_pose = (op == OP_POSE);
    s0_side_next.pidx = pose_index;
    s0_side_next.pval = pose_value;
    s0_side_next.depth = depth_mm;
    s0_side_next.sx = off_x[16];
    s0_side_next.sy = off_y[16];
  end

  dpw_side_t s0_side;
  logic [14:0] s0_mx;
  logic [14:0] s0_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side.vld <= 1'b0;
    end else if (adv) begin
      s0_side <= s0_side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mx <= off_x[16] ? 15'(-off_x) : off_x[14:0];
      s0_my <= off_y[16] ? 15'(-off_y) : off_y[14:0];
    end
  end

  // Stage 1: offset magnitude times depth.
  dpw_side_t s1_side;
  logic [34:0] s1_px;
  logic [34:0] s1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.vld <= 1'b0;
    end else if (adv) begin
      s1_side <= s0_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px <= {20'd0, s0_mx} * {15'd0, s0_side.depth};
      s1_py <= {20'd0, s0_my} * {15'd0, s0_side.depth};
    end
  end

  // Stage 2: add half the focal length so the quotient rounds to nearest.
  dpw_side_t s2_side;
  logic [DIV_W-1:0] s2_nx;
  logic [DIV_W-1:0] s2_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.vld <= 1'b0;
    end else if (adv) begin
      s2_side <= s1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nx <= {1'b0, s1_px} + {19'd0, fx_eff[17:1]};
      s2_ny <= {1'b0, s1_py} + {19'd0, fy_eff[17:1]};
    end
  end

  // Divider stages, with the item information carried alongside.
  logic [DIV_W-1:0] qx;
  logic [DIV_W-1:0] qy;
  dpw_side_t dv_side [DIV_STAGES];

  dpw_div u_div_x (
    .clk(clk),
    .en(adv),
    .dividend(s2_nx),
    .divisor(fx_eff),
    .quotient(qx)
  );

  dpw_div u_div_y (
    .clk(clk),
    .en(adv),
    .dividend(s2_ny),
    .divisor(fy_eff),
    .quotient(qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_side[k].vld <= 1'b0;
      end
    end else if (adv) begin
      dv_side[0] <= s2_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // Stage C: signed camera coordinates.
  dpw_side_t c_side;
  logic signed [35:0] c_cam [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side.vld <= 1'b0;
    end else if (adv) begin
      c_side <= dv_side[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_cam[0] <= dv_side[DIV_STAGES-1].sx ? -$signed({1'b0, qx[34:0]})
                                             : $signed({1'b0, qx[34:0]});
      c_cam[1] <= dv_side[DIV_STAGES-1].sy ? -$signed({1'b0, qy[34:0]})
                                             : $signed({1'b0, qy[34:0]});
      c_cam[2] <= $signed({16'd0, dv_side[DIV_STAGES-1].depth});
    end
  end

  // Pose store. Each group of words is written in the stage that reads it,
  // so a load affects exactly the pixels that came after it.
  logic signed [31:0] rot [ROT_WORDS];
  logic signed [31:0] trans [3];
  logic signed [31:0] body [3];
  dpw_side_t a_side;
  dpw_side_t t_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROT_WORDS; k++) begin
        rot[k] <= (k == 0 || k == 4 || k == 8) ? 32'sd65536 : 32'sd0;
      end
    end else if (adv && c_side.vld && c_side.is_pose) begin
      for (int k = 0; k < ROT_WORDS; k++) begin
        if (c_side.pidx == 4'(k)) begin
          rot[k] <= c_side.pval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        trans[k] <= 32'sd0;
      end
    end else if (adv && a_side.vld && a_side.is_pose) begin
      for (int k = 0; k < 3; k++) begin
        if (a_side.pidx == 4'(POSE_T_BASE + k)) begin
          trans[k] <= a_side.pval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        body[k] <= 32'sd0;
      end
    end else if (adv && t_side.vld && t_side.is_pose) begin
      for (int k = 0; k < 3; k++) begin
        if (t_side.pidx == 4'(POSE_B_BASE + k)) begin
          body[k] <= t_side.pval;
        end
      end
    end
  end

  // Stage M: rotation entry times the high and low halves of each coordinate.
  dpw_side_t m_side;
  logic signed [35:0] m_ph_next [ROT_WORDS];
  logic signed [36:0] m_pl_next [ROT_WORDS];
  logic signed [35:0] m_ph [ROT_WORDS];
  logic signed [36:0] m_pl [ROT_WORDS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_ph_next[3*i+j] = clamp_rot(rot[3*i+j]) * $signed(c_cam[j][35:18]);
        m_pl_next[3*i+j] = clamp_rot(rot[3*i+j]) * $signed({1'b0, c_cam[j][17:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_side.vld <= 1'b0;
    end else if (adv) begin
      m_side <= c_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ROT_WORDS; k++) begin
        m_ph[k] <= m_ph_next[k];
        m_pl[k] <= m_pl_next[k];
      end
    end
  end

  // Stage P: join the two partial products of each entry.
  dpw_side_t p_side;
  logic signed [54:0] p_prod [ROT_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_side.vld <= 1'b0;
    end else if (adv) begin
      p_side <= m_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ROT_WORDS; k++) begin
        p_prod[k] <= {m_ph[k][35], m_ph[k], 18'd0} + {{18{m_pl[k][36]}}, m_pl[k]};
      end
    end
  end

  // Stage A: row sums with the rounding offset for the Q1.16 scale.
  logic signed [56:0] a_acc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_side.vld <= 1'b0;
    end else if (adv) begin
      a_side <= p_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_acc[i] <= 57'(p_prod[3*i]) + 57'(p_prod[3*i+1]) + 57'(p_prod[3*i+2]) +
                    57'sd32768;
      end
    end
  end

  // Stage T: scale down (floor) and add the camera translation.
  logic signed [41:0] t_world [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_side.vld <= 1'b0;
    end else if (adv) begin
      t_side <= a_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t_world[i] <= 42'($signed(a_acc[i][56:16])) + 42'(trans[i]);
      end
    end
  end

  // Stage D: offsets from the body position and the per-axis range check.
  logic signed [42:0] diff [3];
  logic axes_ok;
  logic d_vld;
  logic signed [20:0] d_diff [3];
  logic signed [41:0] d_world [3];

  always_comb begin
    axes_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      diff[i] = 43'(t_world[i]) - 43'(body[i]);
      if (diff[i] > $signed({23'd0, horizon_mm}) || diff[i] < -$signed({23'd0, horizon_mm}))
      begin
        axes_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= t_side.vld && !t_side.is_pose && axes_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_diff[i] <= diff[i][20:0];
        d_world[i] <= t_world[i];
      end
    end
  end

  // Stage Q: squares of the offsets.
  logic signed [41:0] sq_full [3];
  logic q_vld;
  logic [39:0] q_sq [3];
  logic signed [41:0] q_world [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = d_diff[i] * d_diff[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (adv) begin
      q_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q_sq[i] <= sq_full[i][39:0];
        q_world[i] <= d_world[i];
      end
    end
  end

  // Stage E: distance test against the horizon and saturation.
  logic [41:0] dist_sq;
  logic signed [31:0] e_world [3];

  assign dist_sq = {2'b00, q_sq[0]} + {2'b00, q_sq[1]} + {2'b00, q_sq[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= q_vld && (dist_sq <= {2'b00, horizon_sq});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e_world[i] <= sat32(q_world[i]);
      end
    end
  end

  // Output register: loads a kept point, clears after its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (adv && e_vld) begin
      point_valid <= 1'b1;
    end else if (!point_stall) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e_vld) begin
      world_x <= e_world[0];
      world_y <= e_world[1];
      world_z <= e_world[2];
    end
  end

endmodule
